>>> hw/rtl/tzsam_pkg.sv
// Package for the time-zone shift and alarm match block.
// Holds the transaction payload types, the register set and register indexes.
// No dependencies.
package tzsam_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REG_ZONE_OFFSET   = 2'd0;
   localparam logic [1:0] REG_ALARM_HOURS   = 2'd1;
   localparam logic [1:0] REG_ALARM_MINUTES = 2'd2;
   localparam logic [1:0] REG_ALARM_ENABLED = 2'd3;

   localparam logic ACTION_STORE = 1'b0;
   localparam logic ACTION_TICK  = 1'b1;

   // The radio time arrives in UTC+1.
   localparam logic signed [6:0] RADIO_ZONE = 7'sd1;
   localparam logic [4:0] SYNC_HOUR   = 5'd4;
   localparam logic [5:0] SYNC_MINUTE = 6'd0;

   typedef struct packed {
      logic       action;
      logic       apply_shift;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
   } req_type;

   typedef struct packed {
      logic [4:0] out_hours;
      logic [5:0] out_minutes;
      logic [4:0] out_day;
      logic [3:0] out_month;
      logic [6:0] out_year;
      logic       sync_due;
      logic       alarm_due;
   } rsp_type;

   typedef struct packed {
      logic signed [4:0] zone_offset;
      logic [4:0]        alarm_hours;
      logic [5:0]        alarm_minutes;
      logic              alarm_enabled;
   } cfg_type;

endpackage

>>> hw/rtl/tzsam_pipe.sv
// Three-stage calendar pipeline: hour shift, midnight wrap, day and month carry.
// Depends on tzsam_pkg for the payload and register types.
module tzsam_pipe
   import tzsam_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   input  req_type in_item,
   output logic    out_valid,
   output rsp_type out_item
);

   function automatic logic is_leap(input logic [6:0] yy);
      // 2000 + yy is a leap year when yy is a multiple of four, except 2100.
      return (yy[1:0] == 2'b00) && (yy != 7'd100);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] mo, input logic [6:0] yy);
      logic [4:0] len;
      case (mo)
         4'd2:    len = is_leap(yy) ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // Stage 1: shifted hour sum, month lengths, tick flags.
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_shift_ff, s1_shift_in;
   logic signed [6:0] s1_hour_ff, s1_hour_in;
   logic [5:0]        s1_minutes_ff;
   logic [4:0]        s1_day_ff, s1_hours_raw_ff;
   logic [3:0]        s1_month_ff, s1_prev_month_ff, s1_next_month_ff;
   logic [3:0]        s1_prev_month_in, s1_next_month_in;
   logic [6:0]        s1_year_ff;
   logic [4:0]        s1_dim_ff, s1_prev_dim_ff;
   logic              s1_sync_ff, s1_sync_in, s1_alarm_ff, s1_alarm_in;

   assign s1_valid_in = in_valid;
   assign s1_shift_in = (in_item.action == ACTION_STORE) && in_item.apply_shift;
   assign s1_hour_in  = $signed({2'b00, in_item.hours})
                      + $signed({{2{cfg.zone_offset[4]}}, cfg.zone_offset}) - RADIO_ZONE;
   assign s1_prev_month_in = (in_item.month <= 4'd1) ? 4'd12 : in_item.month - 4'd1;
   assign s1_next_month_in = (in_item.month >= 4'd12) ? 4'd1 : in_item.month + 4'd1;

   always_comb begin
      s1_sync_in  = 1'b0;
      s1_alarm_in = 1'b0;
      if (in_item.action == ACTION_TICK) begin
         s1_sync_in  = (in_item.seconds == 6'd0) && (in_item.minutes == SYNC_MINUTE)
                     && (in_item.hours == SYNC_HOUR);
         s1_alarm_in = cfg.alarm_enabled && (in_item.seconds == 6'd0)
                     && (in_item.minutes == cfg.alarm_minutes)
                     && (in_item.hours == cfg.alarm_hours);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_shift_ff      <= s1_shift_in;
      s1_hour_ff       <= s1_hour_in;
      s1_hours_raw_ff  <= in_item.hours;
      s1_minutes_ff    <= in_item.minutes;
      s1_day_ff        <= in_item.day;
      s1_month_ff      <= in_item.month;
      s1_prev_month_ff <= s1_prev_month_in;
      s1_next_month_ff <= s1_next_month_in;
      s1_year_ff       <= in_item.year;
      s1_dim_ff        <= month_days(in_item.month, in_item.year);
      s1_prev_dim_ff   <= month_days(s1_prev_month_in, in_item.year);
      s1_sync_ff       <= s1_sync_in;
      s1_alarm_ff      <= s1_alarm_in;
   end

   // Stage 2: bring the hour into range and carry one day forward or back.
   logic              s2_valid_ff;
   logic              s2_shift_ff;
   logic [4:0]        s2_hour_ff, s2_hour_in;
   logic signed [6:0] s2_day_ff, s2_day_in;
   logic [5:0]        s2_minutes_ff;
   logic [3:0]        s2_month_ff, s2_prev_month_ff, s2_next_month_ff;
   logic [6:0]        s2_year_ff;
   logic [4:0]        s2_dim_ff, s2_prev_dim_ff;
   logic              s2_sync_ff, s2_alarm_ff;

   always_comb begin
      logic signed [6:0] day_s;
      logic signed [6:0] hour_w;
      day_s  = $signed({2'b00, s1_day_ff});
      hour_w = s1_hour_ff;
      if (s1_hour_ff < 7'sd0) begin
         hour_w = s1_hour_ff + 7'sd24;
         day_s  = day_s - 7'sd1;
      end else if (s1_hour_ff >= 7'sd24) begin
         hour_w = s1_hour_ff - 7'sd24;
         day_s  = day_s + 7'sd1;
      end
      if (s1_shift_ff) begin
         s2_hour_in = hour_w[4:0];
         s2_day_in  = day_s;
      end else begin
         s2_hour_in = s1_hours_raw_ff;
         s2_day_in  = $signed({2'b00, s1_day_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_shift_ff      <= s1_shift_ff;
      s2_hour_ff       <= s2_hour_in;
      s2_day_ff        <= s2_day_in;
      s2_minutes_ff    <= s1_minutes_ff;
      s2_month_ff      <= s1_month_ff;
      s2_prev_month_ff <= s1_prev_month_ff;
      s2_next_month_ff <= s1_next_month_ff;
      s2_year_ff       <= s1_year_ff;
      s2_dim_ff        <= s1_dim_ff;
      s2_prev_dim_ff   <= s1_prev_dim_ff;
      s2_sync_ff       <= s1_sync_ff;
      s2_alarm_ff      <= s1_alarm_ff;
   end

   // Stage 3: day out of range moves into the neighboring month.
   logic    out_valid_ff;
   rsp_type out_item_ff, out_item_in;

   always_comb begin
      out_item_in.out_hours   = s2_hour_ff;
      out_item_in.out_minutes = s2_minutes_ff;
      out_item_in.out_day     = s2_day_ff[4:0];
      out_item_in.out_month   = s2_month_ff;
      out_item_in.out_year    = s2_year_ff;
      out_item_in.sync_due    = s2_sync_ff;
      out_item_in.alarm_due   = s2_alarm_ff;
      if (s2_shift_ff) begin
         if (s2_day_ff < 7'sd1) begin
            out_item_in.out_day   = s2_prev_dim_ff;
            out_item_in.out_month = s2_prev_month_ff;
         end else if (s2_day_ff > $signed({2'b00, s2_dim_ff})) begin
            out_item_in.out_day   = 5'd1;
            out_item_in.out_month = s2_next_month_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s2_valid_ff;
      end
      out_item_ff <= out_item_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

>>> hw/rtl/timezone_shift_and_alarm_match.sv
// Top level of the time-zone shift and alarm match block: register file and pipeline.
// Depends on tzsam_pkg and tzsam_pipe.
//
//   channel   ports                                   direction
//   request   start, busy, req_item                   in (busy out)
//   response  rsp_valid, rsp_item                     out
//   config    psel, penable, pwrite, paddr, pwdata,   in (prdata, pready out)
//             prdata, pready
//
// A transaction is taken in every cycle; busy is always low.
// Each result is held for one cycle under rsp_valid.
// Between a start and its result lie the three register stages of tzsam_pipe.
// Synchronous reset clears the pipeline valid bits and loads the register reset values.
// The receiver cannot stall, so the pipeline never holds.
module timezone_shift_and_alarm_match
   import tzsam_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_item,
   output logic                      rsp_valid,
   output rsp_type                   rsp_item,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type    cfg_ff;
   logic       csr_write;
   logic [1:0] csr_index;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zone_offset   <= 5'sd1;
         cfg_ff.alarm_hours   <= 5'd0;
         cfg_ff.alarm_minutes <= 6'd0;
         cfg_ff.alarm_enabled <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_ZONE_OFFSET:   cfg_ff.zone_offset   <= $signed(pwdata[4:0]);
            REG_ALARM_HOURS:   cfg_ff.alarm_hours   <= pwdata[4:0];
            REG_ALARM_MINUTES: cfg_ff.alarm_minutes <= pwdata[5:0];
            REG_ALARM_ENABLED: cfg_ff.alarm_enabled <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ZONE_OFFSET:   prdata = {27'd0, cfg_ff.zone_offset};
         REG_ALARM_HOURS:   prdata = {27'd0, cfg_ff.alarm_hours};
         REG_ALARM_MINUTES: prdata = {26'd0, cfg_ff.alarm_minutes};
         REG_ALARM_ENABLED: prdata = {31'd0, cfg_ff.alarm_enabled};
         default:           prdata = '0;
      endcase
   end

   tzsam_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (start && !busy),
      .in_item   (req_item),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

endmodule

>>> tb/tzsam_checker.sv
`timescale 1ns / 100ps
// Checker for the time-zone shift and alarm match block: predicts each result and compares it.
// Depends on tzsam_pkg; watches the request, response and register ports of the block.
module tzsam_checker
   import tzsam_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  req_type                   req_item,
   input  logic                      rsp_valid,
   input  rsp_type                   rsp_item,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic                      pready,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output int unsigned               pending_count,
   output int unsigned               mismatch_count
);

   // Shadow copy of the register set, updated from observed writes.
   int         zone_hours = 1;
   logic [4:0] alarm_hr   = '0;
   logic [5:0] alarm_min  = '0;
   logic       alarm_on   = 1'b0;

   rsp_type expected_times[$];

   function automatic bit has_feb29(input logic [6:0] yy);
      int full;
      full = 2000 + int'(yy);
      return (full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0));
   endfunction

   // Months outside 1..12 count as 31 days long.
   function automatic int month_span(input int mo, input logic [6:0] yy);
      if (mo == 2 && has_feb29(yy)) begin
         return 29;
      end
      case (mo)
         2:           return 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic rsp_type predict_local_time(input req_type t);
      rsp_type r;
      int      h;
      int      d;
      int      m;
      r.out_hours   = t.hours;
      r.out_minutes = t.minutes;
      r.out_day     = t.day;
      r.out_month   = t.month;
      r.out_year    = t.year;
      r.sync_due    = 1'b0;
      r.alarm_due   = 1'b0;
      if (t.action == ACTION_STORE) begin
         if (t.apply_shift) begin
            h = int'(t.hours) + zone_hours - int'(RADIO_ZONE);
            d = int'(t.day);
            m = int'(t.month);
            if (h < 0) begin
               h += 24;
               d--;
            end else if (h >= 24) begin
               h -= 24;
               d++;
            end
            // The day is brought back into range even when the hour did not wrap.
            if (d < 1) begin
               m--;
               if (m < 1) begin
                  m = 12;
               end
               d = month_span(m, t.year);
            end else if (d > month_span(m, t.year)) begin
               d = 1;
               m++;
               if (m > 12) begin
                  m = 1;
               end
            end
            r.out_hours = 5'(h);
            r.out_day   = 5'(d);
            r.out_month = 4'(m);
         end
      end else begin
         r.sync_due  = (t.seconds == 6'd0) && (t.minutes == SYNC_MINUTE)
                       && (t.hours == SYNC_HOUR);
         r.alarm_due = alarm_on && (t.seconds == 6'd0) && (t.minutes == alarm_min)
                       && (t.hours == alarm_hr);
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [6:0] want,
                              input logic [6:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_times.delete();
         zone_hours     = 1;
         alarm_hr       = '0;
         alarm_min      = '0;
         alarm_on       = 1'b0;
         mismatch_count = 0;
      end else begin
         // Compare before queuing, so a response can never match the transaction
         // accepted in the same cycle.
         if (rsp_valid) begin
            if (expected_times.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_item);
               mismatch_count++;
            end else begin
               want = expected_times.pop_front();
               check_field("out_hours", 7'(want.out_hours), 7'(rsp_item.out_hours));
               check_field("out_minutes", 7'(want.out_minutes), 7'(rsp_item.out_minutes));
               check_field("out_day", 7'(want.out_day), 7'(rsp_item.out_day));
               check_field("out_month", 7'(want.out_month), 7'(rsp_item.out_month));
               check_field("out_year", 7'(want.out_year), 7'(rsp_item.out_year));
               check_field("sync_due", 7'(want.sync_due), 7'(rsp_item.sync_due));
               check_field("alarm_due", 7'(want.alarm_due), 7'(rsp_item.alarm_due));
            end
         end
         if (start && !busy) begin
            expected_times.push_back(predict_local_time(req_item));
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_WIDTH-1:2])
               REG_ZONE_OFFSET:   zone_hours = $signed(pwdata[4:0]);
               REG_ALARM_HOURS:   alarm_hr   = pwdata[4:0];
               REG_ALARM_MINUTES: alarm_min  = pwdata[5:0];
               REG_ALARM_ENABLED: alarm_on   = pwdata[0];
               default: ;
            endcase
         end
      end
      pending_count = expected_times.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the time-zone shift and alarm match block: stimulus, watchdog and verdict.
// Depends on tzsam_pkg, timezone_shift_and_alarm_match and tzsam_checker.
module tb;
   import tzsam_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 75;

   logic                      clock   = 1'b0;
   logic                      reset   = 1'b1;
   logic                      start   = 1'b0;
   logic                      busy;
   req_type                   req_item = '0;
   logic                      rsp_valid;
   rsp_type                   rsp_item;
   logic                      psel    = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int unsigned pending_count;
   int unsigned mismatch_count;
   int          idle_cycles = 0;
   int          burst_left  = 1;
   logic [4:0]  alarm_hr_set  = '0;
   logic [5:0]  alarm_min_set = '0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   timezone_shift_and_alarm_match u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   tzsam_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pending_count  (pending_count),
      .mismatch_count (mismatch_count)
   );

   // Any accepted transaction on any port restarts the count.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   function automatic req_type make_time(input logic act, input logic shift, input int hh,
                                         input int mm, input int ss, input int dd,
                                         input int mo, input int yy);
      req_type t;
      t.action      = act;
      t.apply_shift = shift;
      t.hours       = 5'(hh);
      t.minutes     = 6'(mm);
      t.seconds     = 6'(ss);
      t.day         = 5'(dd);
      t.month       = 4'(mo);
      t.year        = 7'(yy);
      return t;
   endfunction

   // Mostly valid calendar values, leaning on month ends and on times that
   // can raise sync or alarm; a share of out-of-range field values besides.
   function automatic req_type random_time();
      req_type t;
      t.action      = ($urandom_range(0, 1) != 0) ? ACTION_TICK : ACTION_STORE;
      t.apply_shift = ($urandom_range(0, 9) != 0);
      t.hours   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                             : 5'($urandom_range(0, 23));
      t.minutes = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                             : 6'($urandom_range(0, 59));
      t.seconds = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                             : 6'($urandom_range(0, 59));
      case ($urandom_range(0, 7))
         0:       t.day = 5'($urandom_range(0, 1));
         1, 2:    t.day = 5'($urandom_range(28, 31));
         default: t.day = 5'($urandom_range(1, 31));
      endcase
      t.month = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 12));
      t.year  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                           : 7'($urandom_range(0, 99));
      if (t.action == ACTION_TICK) begin
         case ($urandom_range(0, 3))
            0: begin
               t.hours   = SYNC_HOUR;
               t.minutes = SYNC_MINUTE;
            end
            1: begin
               t.hours   = alarm_hr_set;
               t.minutes = alarm_min_set;
            end
            default: ;
         endcase
         if ($urandom_range(0, 1) != 0) begin
            t.seconds = '0;
         end
      end
      return t;
   endfunction

   task automatic send_item(input req_type t);
      @(negedge clock);
      start    <= 1'b1;
      req_item <= t;
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Stops the sender and waits until every transaction in flight has produced its result.
   task automatic drain_block();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic set_clock_config(input int zone, input logic [4:0] ah, input logic [5:0] am,
                                   input logic en);
      drain_block();
      write_register(REG_ZONE_OFFSET, CSR_DATA_WIDTH'(zone));
      write_register(REG_ALARM_HOURS, CSR_DATA_WIDTH'(ah));
      write_register(REG_ALARM_MINUTES, CSR_DATA_WIDTH'(am));
      write_register(REG_ALARM_ENABLED, CSR_DATA_WIDTH'(en));
      alarm_hr_set  = ah;
      alarm_min_set = am;
   endtask

   initial begin
      int zone;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 24);

      // Reset settings: zero net shift, alarm disabled at midnight.
      send_item(make_time(ACTION_STORE, 1'b1, 23, 59, 59, 31, 12, 99));
      send_item(make_time(ACTION_STORE, 1'b1, 31, 63, 63, 31, 12, 127));
      send_item(make_time(ACTION_STORE, 1'b0, 0, 0, 0, 0, 0, 0));
      send_item(make_time(ACTION_STORE, 1'b1, 10, 0, 0, 0, 0, 0));
      send_item(make_time(ACTION_STORE, 1'b1, 10, 0, 0, 31, 4, 10));
      send_item(make_time(ACTION_STORE, 1'b1, 10, 0, 0, 20, 15, 10));
      send_item(make_time(ACTION_TICK, 1'b0, 4, 0, 0, 1, 1, 0));
      send_item(make_time(ACTION_TICK, 1'b0, 0, 0, 0, 1, 1, 0));
      send_item(make_time(ACTION_TICK, 1'b1, 4, 0, 1, 1, 1, 0));

      // Westmost zone: backward wraps, including into a leap and a non-leap February.
      set_clock_config(-12, 5'd23, 6'd59, 1'b1);
      send_item(make_time(ACTION_STORE, 1'b1, 0, 30, 0, 1, 1, 0));
      send_item(make_time(ACTION_STORE, 1'b1, 5, 0, 0, 1, 3, 0));
      send_item(make_time(ACTION_STORE, 1'b1, 5, 0, 0, 1, 3, 1));
      send_item(make_time(ACTION_STORE, 1'b1, 5, 0, 0, 1, 3, 100));
      send_item(make_time(ACTION_STORE, 1'b1, 31, 0, 0, 15, 6, 20));
      send_item(make_time(ACTION_TICK, 1'b0, 23, 59, 0, 1, 1, 0));
      send_item(make_time(ACTION_TICK, 1'b0, 23, 59, 1, 1, 1, 0));
      send_item(make_time(ACTION_STORE, 1'b0, 0, 0, 0, 1, 1, 0));

      // Eastmost zone: forward wraps across month and year ends.
      set_clock_config(14, 5'd4, 6'd0, 1'b1);
      send_item(make_time(ACTION_TICK, 1'b0, 4, 0, 0, 1, 1, 0));
      send_item(make_time(ACTION_STORE, 1'b1, 23, 0, 0, 31, 12, 99));
      send_item(make_time(ACTION_STORE, 1'b1, 20, 0, 0, 29, 2, 1));
      send_item(make_time(ACTION_STORE, 1'b1, 20, 0, 0, 28, 2, 4));
      send_item(make_time(ACTION_STORE, 1'b1, 20, 0, 0, 31, 13, 5));
      send_item(make_time(ACTION_STORE, 1'b1, 31, 0, 0, 10, 7, 50));

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       zone = -16;
            1:       zone = 15;
            2:       zone = -12;
            3:       zone = 14;
            default: zone = int'($urandom_range(0, 31)) - 16;
         endcase
         set_clock_config(zone,
                          ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                                      : 5'($urandom_range(0, 23)),
                          ($urandom_range(0, 7) == 0) ? 6'($urandom_range(60, 63))
                                                      : 6'($urandom_range(0, 59)),
                          ($urandom_range(0, 3) != 0));
         repeat (PHASE_ITEMS) send_item(random_time());
      end

      drain_block();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

>>> timezone_shift_and_alarm_match.f
hw/rtl/tzsam_pkg.sv
hw/rtl/tzsam_pipe.sv
hw/rtl/timezone_shift_and_alarm_match.sv
tb/tzsam_checker.sv
tb/tb.sv
